// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the line rasterizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is held
`define BRL_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define BRL_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/brl_pkg.sv
// ---------------------------------------------------------------------------
// brl_pkg
// Types and constants shared by the line rasterizer controller and datapath.
// ---------------------------------------------------------------------------
package brl_pkg;

    // Width of every coordinate field on the stream ports
    localparam int COORD_W = 6;

    // Packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the request endpoints
        logic setup;    // compute deltas, decision term and step count
        logic step;     // advance to the next pixel
    } brl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;     // current pixel is the final one of the line
        logic bad;      // request runs in the wrong direction
    } brl_stat_t;

endpackage

// File: design/brl_ctrl.sv
// ---------------------------------------------------------------------------
// brl_ctrl
// Controller: accepts a line request, runs a setup state, then hands out
// one pixel beat per cycle that the result side takes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module brl_ctrl
    import brl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  brl_stat_t stat,
    output brl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold or advance the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `BRL_ASSERT(a_no_overlap, aclk, aresetn, !(s_tready && m_tvalid), "request taken while a pixel is out")
    `BRL_ASSERT(a_setup_follows, aclk, aresetn, (s_tvalid && s_tready) |=> (state_reg == ST_SETUP), "no setup after accept")
    `BRL_ASSERT(a_run_follows, aclk, aresetn, (state_reg == ST_SETUP) |=> m_tvalid, "no pixel after setup")
    `BRL_ASSERT(a_bad_single, aclk, aresetn, (m_tvalid && stat.bad) |-> stat.last, "wrong-direction line not single pixel")

endmodule

// File: design/brl_dp.sv
// ---------------------------------------------------------------------------
// brl_dp
// Datapath: endpoint registers, decision term, step counter and the current
// pixel, which drives the result beat directly.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module brl_dp
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  brl_cmd_t           cmd,
    output brl_stat_t          stat,
    input  logic [COORD_W-1:0] x_start,
    input  logic [COORD_W-1:0] y_start,
    input  logic [COORD_W-1:0] x_end,
    input  logic [COORD_W-1:0] y_end,
    output logic [COORD_W-1:0] pixel_x,
    output logic [COORD_W-1:0] pixel_y
);

    localparam int CB = COORD_BITS;
    localparam int PW = COORD_BITS + 2;

    logic [CB-1:0]        x_reg;
    logic [CB-1:0]        y_reg;
    logic [CB-1:0]        xe_reg;
    logic [CB-1:0]        ye_reg;
    logic [CB-1:0]        rem_reg;
    logic                 bad_reg;
    logic                 shallow_reg;
    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] inc_lo_reg;
    logic signed [PW-1:0] inc_hi_reg;

    logic [CB-1:0]        dx;
    logic [CB-1:0]        dy;
    logic [CB-1:0]        dmaj;
    logic [CB-1:0]        dmin;
    logic                 bad;
    logic                 shallow;
    logic signed [PW-1:0] dmin2;
    logic signed [PW-1:0] dmaj2;
    logic signed [PW-1:0] p_init;
    logic                 minor_step;

    // Deltas and initial decision term from the captured endpoints
    always_comb begin
        bad     = (xe_reg < x_reg) || (ye_reg < y_reg);
        dx      = xe_reg - x_reg;
        dy      = ye_reg - y_reg;
        shallow = dy < dx;
        dmaj    = shallow ? dx : dy;
        dmin    = shallow ? dy : dx;
        dmin2   = {1'b0, dmin, 1'b0};
        dmaj2   = {1'b0, dmaj, 1'b0};
        p_init  = dmin2 - PW'(dmaj);
    end

    // Step the minor axis when the decision term is non-negative
    assign minor_step = !p_reg[PW-1];

    // Capture, set up and advance the line
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg  <= x_start[CB-1:0];
            y_reg  <= y_start[CB-1:0];
            xe_reg <= x_end[CB-1:0];
            ye_reg <= y_end[CB-1:0];
        end
        if (cmd.setup) begin
            bad_reg     <= bad;
            shallow_reg <= shallow;
            p_reg       <= p_init;
            inc_lo_reg  <= dmin2;
            inc_hi_reg  <= dmin2 - dmaj2;
            rem_reg     <= bad ? '0 : dmaj;
        end
        if (cmd.step) begin
            rem_reg <= rem_reg - 1'b1;
            p_reg   <= p_reg + (minor_step ? inc_hi_reg : inc_lo_reg);
            if (shallow_reg) begin
                x_reg <= x_reg + 1'b1;
                if (minor_step) begin
                    y_reg <= y_reg + 1'b1;
                end
            end else begin
                y_reg <= y_reg + 1'b1;
                if (minor_step) begin
                    x_reg <= x_reg + 1'b1;
                end
            end
        end
    end

    assign stat.last = (rem_reg == '0);
    assign stat.bad  = bad_reg;
    assign pixel_x   = COORD_W'(x_reg);
    assign pixel_y   = COORD_W'(y_reg);

    `BRL_ASSERT(a_step_in_range, aclk, aresetn, cmd.step |-> (rem_reg != '0), "step past the end pixel")
    `BRL_ASSERT(a_count_down, aclk, aresetn, cmd.step |=> (rem_reg == $past(rem_reg) - 1'b1), "step counter slipped")
    `BRL_ASSERT(a_major_moves, aclk, aresetn, (cmd.step && shallow_reg) |=> (x_reg == $past(x_reg) + 1'b1), "major axis did not advance")

endmodule

// File: design/bresenham_line_rasterizer_top.sv
// ---------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// Integer Bresenham line rasterizer: one line request in, every pixel of
// the line out in order, the final pixel marked.
//
//   channel  | dir | beat contents
//   ---------+-----+--------------------------------------------------
//   s_ (req) | in  | x_start, y_start, x_end, y_end
//   m_ (pix) | out | pixel_x, pixel_y; tlast = last_pixel; tuser = bad
//
// A line of N pixels (N = max(dx, dy) + 1, at most 2**COORD_BITS) is
// accepted, set up in a setup state for the decision term, then sent
// one pixel per cycle, while taken, from the datapath's single step loop.
// A new request is taken only after the final pixel beat has been taken.
// Result backpressure holds the current pixel and freezes the step loop.
// Reset is synchronous, active low, and returns the controller to idle.
// ---------------------------------------------------------------------------
module bresenham_line_rasterizer_top
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_x[5:0], pixel_y[11:6], zero[15:12]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    // bad_direction[0]
    output logic                 m_tuser
);

    brl_cmd_t           cmd;
    brl_stat_t          stat;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    brl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brl_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .x_start (s_tdata[COORD_W-1:0]),
        .y_start (s_tdata[2*COORD_W-1:COORD_W]),
        .x_end   (s_tdata[3*COORD_W-1:2*COORD_W]),
        .y_end   (s_tdata[4*COORD_W-1:3*COORD_W]),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y)
    );

    // Pack the pixel beat
    assign m_tdata = M_TDATA_W'({pixel_y, pixel_x});
    assign m_tlast = stat.last;
    assign m_tuser = stat.bad;

endmodule

// File: tb/sv/brl_line_checker.sv
// ---------------------------------------------------------------------------
// brl_line_checker
// Watches the request and pixel streams of the line rasterizer. It rasterizes
// every accepted request on its own, queues the expected pixel beats and
// compares each accepted pixel beat, field by field, with the oldest one.
// ---------------------------------------------------------------------------
module brl_line_checker
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic                 m_tuser,
    output int                   fail_count,
    output int                   pixels_due,
    output int                   lines_seen,
    output int                   pixels_seen,
    output int                   bad_lines
);

    localparam int ERR_W = COORD_W + 4;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
        logic   bad;
    } pixel_t;

    localparam coord_t COORD_MASK = coord_t'((1 << COORD_BITS) - 1);

    pixel_t pixel_q[$];

    // Walk one line request and queue every pixel it should produce
    function automatic void rasterize_line(input logic [S_TDATA_W-1:0] req);
        coord_t                   x0, y0, x1, y1, px, py;
        logic [COORD_W:0]         dx, dy;
        int                       run;
        logic signed [ERR_W-1:0]  dxe, dye, err;
        logic                     steep;
        x0 = req[COORD_W-1:0] & COORD_MASK;
        y0 = req[2*COORD_W-1:COORD_W] & COORD_MASK;
        x1 = req[3*COORD_W-1:2*COORD_W] & COORD_MASK;
        y1 = req[4*COORD_W-1:3*COORD_W] & COORD_MASK;
        // Wrong direction: start pixel only, flagged
        if (x1 < x0 || y1 < y0) begin
            pixel_q.push_back('{x: x0, y: y0, last: 1'b1, bad: 1'b1});
            bad_lines++;
            return;
        end
        dx    = (COORD_W+1)'(x1) - (COORD_W+1)'(x0);
        dy    = (COORD_W+1)'(y1) - (COORD_W+1)'(y0);
        dxe   = ERR_W'(dx);
        dye   = ERR_W'(dy);
        steep = (dy >= dx);
        run   = steep ? int'(dy) : int'(dx);
        err   = steep ? ERR_W'(2 * dxe - dye) : ERR_W'(2 * dye - dxe);
        px    = x0;
        py    = y0;
        pixel_q.push_back('{x: px, y: py, last: (run == 0), bad: 1'b0});
        for (int i = 0; i < run; i++) begin
            if (steep) begin
                py = py + 1'b1;
                if (err < 0) begin
                    err = ERR_W'(err + 2 * dxe);
                end else begin
                    err = ERR_W'(err + 2 * dxe - 2 * dye);
                    px  = px + 1'b1;
                end
            end else begin
                px = px + 1'b1;
                if (err < 0) begin
                    err = ERR_W'(err + 2 * dye);
                end else begin
                    err = ERR_W'(err + 2 * dye - 2 * dxe);
                    py  = py + 1'b1;
                end
            end
            pixel_q.push_back('{x: px, y: py, last: (i == run - 1), bad: 1'b0});
        end
    endfunction

    // Count a failure, report only the first few
    function automatic void flag_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] pixel mismatch: %s", $realtime, msg);
        end
    endfunction

    // Predict on request beats, compare on pixel beats
    always @(posedge aclk) begin
        pixel_t want;
        pixel_t got;
        logic [M_TDATA_W-2*COORD_W-1:0] pad;
        if (!aresetn) begin
            pixel_q.delete();
            fail_count  = 0;
            lines_seen  = 0;
            pixels_seen = 0;
            bad_lines   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                rasterize_line(s_tdata);
                lines_seen++;
            end
            if (m_tvalid && m_tready) begin
                pixels_seen++;
                got = '{x: m_tdata[COORD_W-1:0], y: m_tdata[2*COORD_W-1:COORD_W],
                        last: m_tlast, bad: m_tuser};
                pad = m_tdata[M_TDATA_W-1:2*COORD_W];
                if (pixel_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat x=%0d y=%0d last=%b bad=%b",
                                            got.x, got.y, got.last, got.bad));
                end else begin
                    want = pixel_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
                        got.bad !== want.bad || pad !== '0) begin
                        flag_mismatch($sformatf(
                            "expected x=%0d y=%0d last=%b bad=%b, got x=%0d y=%0d last=%b bad=%b pad=%h",
                            want.x, want.y, want.last, want.bad,
                            got.x, got.y, got.last, got.bad, pad));
                    end
                end
            end
        end
        pixels_due <= pixel_q.size();
    end

endmodule

// File: tb/sv/tb_bresenham_line_rasterizer_top.sv
// ---------------------------------------------------------------------------
// tb_bresenham_line_rasterizer_top
// Drives line requests into the rasterizer: a directed set covering points,
// axis lines, diagonals, shallow and steep slopes and wrong directions, then
// random requests, mostly well-formed, with random idle on both streams
// outside the steady phase. A separate checker predicts and compares every pixel beat.
// ---------------------------------------------------------------------------
module tb_bresenham_line_rasterizer_top;
    import brl_pkg::*;

    localparam int COORD_BITS = 6;
    localparam int MAX_C      = (1 << COORD_BITS) - 1;

    typedef logic [COORD_W-1:0] coord_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    int fail_count;
    int pixels_due;
    int lines_seen;
    int pixels_seen;
    int bad_lines;

    // Both sides run without idle cycles while this is set
    logic steady = 1'b0;

    bresenham_line_rasterizer_top #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    brl_line_checker #(
        .COORD_BITS(COORD_BITS)
    ) line_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pixels_due (pixels_due),
        .lines_seen (lines_seen),
        .pixels_seen(pixels_seen),
        .bad_lines  (bad_lines)
    );

    // Clock, period 8
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Hard stop if the pixel stream hangs
    initial begin
        #8000000;
        $display("Timed out with %0d pixel beats still due", pixels_due);
        $display("RESULT: ERROR");
        $finish;
    end

    // Take pixel beats, with a random stall before each outside the steady phase
    initial begin : pixel_sink
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Send one request beat after a random gap; return at its accepting edge
    task automatic send_line(input coord_t xs, input coord_t ys,
                             input coord_t xe, input coord_t ye);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ye, xe, ys, xs};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off new requests until every predicted pixel has been taken
    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pixels_due != 0);
    endtask

    // Mostly well-formed lines, some points, diagonals and raw noise
    task automatic send_random_line();
        int     kind;
        int     reach;
        coord_t xs, ys, xe, ye;
        kind = $urandom_range(0, 19);
        xs   = coord_t'($urandom_range(0, MAX_C));
        ys   = coord_t'($urandom_range(0, MAX_C));
        case (kind)
            0, 1: begin
                xe = coord_t'($urandom_range(0, MAX_C));
                ye = coord_t'($urandom_range(0, MAX_C));
            end
            2: begin
                xe = xs;
                ye = ys;
            end
            3: begin
                reach = MAX_C - ((xs > ys) ? int'(xs) : int'(ys));
                reach = $urandom_range(0, reach);
                xe    = xs + coord_t'(reach);
                ye    = ys + coord_t'(reach);
            end
            default: begin
                xe = coord_t'($urandom_range(xs, MAX_C));
                ye = coord_t'($urandom_range(ys, MAX_C));
            end
        endcase
        send_line(xs, ys, xe, ye);
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Points, axis lines, diagonals, slopes near the shallow/steep split
        send_line(0, 0, 0, 0);
        send_line(63, 63, 63, 63);
        send_line(0, 0, 63, 0);
        send_line(0, 0, 0, 63);
        send_line(0, 0, 63, 63);
        send_line(0, 0, 63, 62);
        send_line(0, 0, 62, 63);
        send_line(0, 0, 63, 1);
        send_line(0, 0, 1, 63);
        send_line(5, 5, 10, 20);
        send_line(10, 3, 30, 9);
        send_line(3, 4, 5, 6);
        send_line(0, 0, 1, 0);
        send_line(0, 0, 0, 1);
        send_line(0, 0, 2, 1);
        send_line(0, 0, 1, 2);
        send_line(62, 62, 63, 63);
        // Wrong directions: x back, y back, both
        send_line(10, 5, 9, 20);
        send_line(5, 10, 20, 9);
        send_line(63, 63, 0, 0);
        send_line(1, 0, 0, 0);
        send_line(0, 1, 0, 0);
        drain_pixels();

        // Random requests in four phases, the second without idle cycles
        for (int phase = 0; phase < 4; phase++) begin
            steady = (phase == 1);
            repeat (100) send_random_line();
            drain_pixels();
        end
        steady = 1'b0;

        repeat (8) @(posedge aclk);
        $display("Covered %0d line requests (%0d wrong-direction) and %0d pixel beats",
                 lines_seen, bad_lines, pixels_seen);
        $display("with directed edge lines, random slopes and random stalls on both streams");
        if (fail_count == 0 && pixels_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
